// ===== rtl/sbqhp_pkg.sv =====
// shared types and constants of the stereo biquad highpass cascade
// used by sbqhp_ctrl, sbqhp_dp and the top level; no dependencies
package sbqhp_pkg;

    // cascade and number formats
    localparam int SECTIONS       = 5;
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 19;
    localparam int COEF_BITS      = 21;
    localparam int DATA_BITS      = 40;
    localparam int DATA_FRAC      = DATA_BITS - SAMPLE_BITS;
    localparam int REG_BITS       = 3 * COEF_BITS;

    // delay store: x1, x2, y1, y2 per section and channel
    localparam int STORE_DEPTH = SECTIONS * 8;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
    localparam int ROW_BITS    = ADDR_BITS - 2;
    localparam int SEC_BITS    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int CFG_IDX_BITS = 3;

    // multiply-accumulate widths (difference term split into two halves)
    localparam int DIFF_BITS = DATA_BITS + 3;
    localparam int LO_BITS   = 22;
    localparam int HI_BITS   = DIFF_BITS - LO_BITS;
    localparam int MOP_BITS  = LO_BITS + 1;
    localparam int PROD_BITS = COEF_BITS + MOP_BITS;
    localparam int ACC_BITS  = COEF_BITS + DIFF_BITS + 2;
    localparam int MUL_STEPS = 6;
    localparam int STEP_BITS = 3;

    // stream word width, whole bytes
    localparam int TDATA_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    // delay entry codes within one section row
    localparam logic [1:0] ENT_X1 = 2'd0;
    localparam logic [1:0] ENT_X2 = 2'd1;
    localparam logic [1:0] ENT_Y1 = 2'd2;
    localparam logic [1:0] ENT_Y2 = 2'd3;

    // coefficient codes, taken from the upper bits of the multiply step
    localparam logic [1:0] COEF_B0 = 2'd0;
    localparam logic [1:0] COEF_A1 = 2'd1;
    localparam logic [1:0] COEF_A2 = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic                 in_load;
        logic                 ch;
        logic [SEC_BITS-1:0]  sec;
        logic                 rd_en;
        logic [1:0]           rd_sel;
        logic                 cap_en;
        logic [1:0]           cap_sel;
        logic                 diff_en;
        logic                 wr_en;
        logic [1:0]           wr_sel;
        logic                 mul_en;
        logic [STEP_BITS-1:0] mul_step;
        logic                 rnd_en;
        logic                 last_sec;
        logic                 out_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/sbqhp_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module sbqhp_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 40
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/sbqhp_ctrl.sv =====
// sequencer of the biquad cascade: walks channels, sections and multiply steps
// depends on sbqhp_pkg
module sbqhp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sbqhp_pkg::t_dp_sts i_sts,
    output sbqhp_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_READ  = 7'b0000010,
        ST_DIFF  = 7'b0000100,
        ST_MUL   = 7'b0001000,
        ST_TAIL  = 7'b0010000,
        ST_ROUND = 7'b0100000,
        ST_FIN   = 7'b1000000
    } t_state;

    localparam logic [sbqhp_pkg::SEC_BITS-1:0] LAST_SEC =
        sbqhp_pkg::SEC_BITS'(sbqhp_pkg::SECTIONS - 1);
    localparam logic [sbqhp_pkg::STEP_BITS-1:0] LAST_READ = sbqhp_pkg::STEP_BITS'(3);
    localparam logic [sbqhp_pkg::STEP_BITS-1:0] LAST_MUL =
        sbqhp_pkg::STEP_BITS'(sbqhp_pkg::MUL_STEPS - 1);

    t_state                          r_state, n_state;
    logic [sbqhp_pkg::STEP_BITS-1:0] r_step, n_step;
    logic [sbqhp_pkg::SEC_BITS-1:0]  r_sec, n_sec;
    logic                            r_ch, n_ch;
    logic                            w_last_sec;
    sbqhp_pkg::t_dp_cmd              w_cmd;

    assign w_last_sec = (r_sec == LAST_SEC);

    // next state and command decode
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_sec   = r_sec;
        n_ch    = r_ch;
        w_cmd          = '0;
        w_cmd.ch       = r_ch;
        w_cmd.sec      = r_sec;
        w_cmd.mul_step = r_step;
        w_cmd.last_sec = w_last_sec;
        o_in_ready     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    w_cmd.in_load = 1'b1;
                    n_state = ST_READ;
                    n_step  = '0;
                    n_sec   = '0;
                    n_ch    = 1'b0;
                end
            end
            ST_READ: begin
                w_cmd.rd_en  = 1'b1;
                w_cmd.rd_sel = r_step[1:0];
                if (r_step != '0) begin
                    w_cmd.cap_en  = 1'b1;
                    w_cmd.cap_sel = r_step[1:0] - 2'd1;
                end
                if (r_step == LAST_READ) begin
                    n_state = ST_DIFF;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_DIFF: begin
                // last read lands, difference term formed, x stored
                w_cmd.cap_en  = 1'b1;
                w_cmd.cap_sel = sbqhp_pkg::ENT_Y2;
                w_cmd.diff_en = 1'b1;
                w_cmd.wr_en   = 1'b1;
                w_cmd.wr_sel  = sbqhp_pkg::ENT_X1;
                n_state = ST_MUL;
                n_step  = '0;
            end
            ST_MUL: begin
                w_cmd.mul_en = 1'b1;
                // shift the older delay entries while the multiplier runs
                if (r_step == sbqhp_pkg::STEP_BITS'(0)) begin
                    w_cmd.wr_en  = 1'b1;
                    w_cmd.wr_sel = sbqhp_pkg::ENT_X2;
                end else if (r_step == sbqhp_pkg::STEP_BITS'(1)) begin
                    w_cmd.wr_en  = 1'b1;
                    w_cmd.wr_sel = sbqhp_pkg::ENT_Y2;
                end
                if (r_step == LAST_MUL) begin
                    n_state = ST_TAIL;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_TAIL: begin
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                w_cmd.rnd_en = 1'b1;
                w_cmd.wr_en  = 1'b1;
                w_cmd.wr_sel = sbqhp_pkg::ENT_Y1;
                n_step = '0;
                if (!w_last_sec) begin
                    n_sec   = r_sec + 1'b1;
                    n_state = ST_READ;
                end else if (!r_ch) begin
                    n_ch    = 1'b1;
                    n_sec   = '0;
                    n_state = ST_READ;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_cmd = w_cmd;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_sec   <= '0;
            r_ch    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_sec   <= n_sec;
            r_ch    <= n_ch;
        end
    end

    // a new word always starts at the left channel, first section
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.in_load |=> (r_state == ST_READ && r_sec == '0 && !r_ch && r_step == '0))
        else $error("frame start does not reset the section walk");

    // the right channel's last section always hands over to the output stage
    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && w_last_sec && r_ch) |=> (r_state == ST_FIN))
        else $error("cascade end does not reach the output stage");

endmodule

// ===== rtl/sbqhp_dp.sv =====
// datapath: coefficient registers, delay store, shared multiplier and accumulator
// depends on sbqhp_pkg and sbqhp_ram
module sbqhp_dp (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  sbqhp_pkg::t_dp_cmd                      i_cmd,
    output sbqhp_pkg::t_dp_sts                      o_sts,
    input  logic [sbqhp_pkg::TDATA_BITS-1:0]        i_in_data,
    input  logic                                    i_cfg_wr_en,
    input  logic [sbqhp_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [sbqhp_pkg::REG_BITS-1:0]          i_cfg_wdata,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic [sbqhp_pkg::TDATA_BITS-1:0]        o_out_data
);

    localparam int DB = sbqhp_pkg::DATA_BITS;
    localparam int AB = sbqhp_pkg::ACC_BITS;
    localparam int SB = sbqhp_pkg::SAMPLE_BITS;
    localparam int CB = sbqhp_pkg::COEF_BITS;
    localparam logic signed [AB-1:0] ACC_HALF =
        AB'(1) <<< (sbqhp_pkg::COEF_FRAC_BITS - 1);
    localparam logic signed [AB-1:0] DATA_MAX = (AB'(1) <<< (DB - 1)) - AB'(1);
    localparam logic signed [AB-1:0] DATA_MIN = -(AB'(1) <<< (DB - 1));

    // output conversion: round half up, drop fraction, saturate
    function automatic logic [SB-1:0] f_to_sample(input logic signed [DB-1:0] v);
        logic signed [DB:0] s;
        logic signed [DB:0] q;
        logic signed [DB:0] smax;
        logic signed [DB:0] smin;
        smax = ((DB + 1)'(1) <<< (SB - 1)) - (DB + 1)'(1);
        smin = -((DB + 1)'(1) <<< (SB - 1));
        s = (DB + 1)'(v) + ((DB + 1)'(1) <<< (sbqhp_pkg::DATA_FRAC - 1));
        q = s >>> sbqhp_pkg::DATA_FRAC;
        if (q > smax) begin
            f_to_sample = smax[SB-1:0];
        end else if (q < smin) begin
            f_to_sample = smin[SB-1:0];
        end else begin
            f_to_sample = q[SB-1:0];
        end
    endfunction

    logic [sbqhp_pkg::REG_BITS-1:0]           r_coef [sbqhp_pkg::SECTIONS];
    logic [sbqhp_pkg::STORE_DEPTH-1:0]        r_vld;
    logic                                     r_rd_ok;
    logic signed [SB-1:0]                     r_in_r;
    logic signed [DB-1:0]                     r_x, r_x1, r_x2, r_y1, r_y2, r_yl;
    logic signed [sbqhp_pkg::DIFF_BITS-1:0]   r_d;
    logic signed [sbqhp_pkg::PROD_BITS-1:0]   r_prod;
    logic                                     r_prod_vld, r_prod_hi, r_prod_neg;
    logic signed [AB-1:0]                     r_acc;
    logic                                     r_out_vld;
    logic [SB-1:0]                            r_out_l, r_out_r;

    logic [sbqhp_pkg::ROW_BITS-1:0]           w_row;
    logic [sbqhp_pkg::ADDR_BITS-1:0]          w_rd_addr, w_wr_addr;
    logic [DB-1:0]                            w_rd_data, w_wr_data;
    logic signed [DB-1:0]                     w_rd_val;
    logic [sbqhp_pkg::REG_BITS-1:0]           w_coef;
    logic signed [CB-1:0]                     w_mul_c;
    logic signed [sbqhp_pkg::DIFF_BITS-1:0]   w_mul_v;
    logic signed [sbqhp_pkg::MOP_BITS-1:0]    w_mul_h;
    logic signed [sbqhp_pkg::PROD_BITS-1:0]   n_prod;
    logic signed [AB-1:0]                     w_term, n_acc;
    logic signed [AB-1:0]                     w_rnd_sum, w_rnd_shift;
    logic signed [DB-1:0]                     w_y;

    // delay store addressing: one row of four entries per section and channel
    assign w_row = (i_cmd.ch ? sbqhp_pkg::ROW_BITS'(sbqhp_pkg::SECTIONS)
                             : sbqhp_pkg::ROW_BITS'(0))
                 + sbqhp_pkg::ROW_BITS'(i_cmd.sec);
    assign w_rd_addr = {w_row, i_cmd.rd_sel};
    assign w_wr_addr = {w_row, i_cmd.wr_sel};

    // write data follows the entry being written
    always_comb begin
        unique case (i_cmd.wr_sel)
            sbqhp_pkg::ENT_X1: w_wr_data = r_x;
            sbqhp_pkg::ENT_X2: w_wr_data = r_x1;
            sbqhp_pkg::ENT_Y1: w_wr_data = w_y;
            sbqhp_pkg::ENT_Y2: w_wr_data = r_y1;
            default:           w_wr_data = r_x;
        endcase
    end

    sbqhp_ram #(
        .WIDTH (DB),
        .DEPTH (sbqhp_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // never-written entries read as zero
    assign w_rd_val = r_rd_ok ? signed'(w_rd_data) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_cmd.wr_en) begin
                r_vld[w_wr_addr] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rd_ok <= r_vld[w_rd_addr];
            end
        end
    end

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sbqhp_pkg::SECTIONS; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_wr_en && (int'(i_cfg_idx) < sbqhp_pkg::SECTIONS)) begin
            r_coef[i_cfg_idx[sbqhp_pkg::SEC_BITS-1:0]] <= i_cfg_wdata;
        end
    end

    assign w_coef = r_coef[i_cmd.sec];

    // multiplier operands: coefficient times one half of the data term
    always_comb begin
        unique case (i_cmd.mul_step[2:1])
            sbqhp_pkg::COEF_B0: begin
                w_mul_c = signed'(w_coef[CB-1:0]);
                w_mul_v = r_d;
            end
            sbqhp_pkg::COEF_A1: begin
                w_mul_c = signed'(w_coef[2*CB-1:CB]);
                w_mul_v = sbqhp_pkg::DIFF_BITS'(r_y1);
            end
            sbqhp_pkg::COEF_A2: begin
                w_mul_c = signed'(w_coef[3*CB-1:2*CB]);
                w_mul_v = sbqhp_pkg::DIFF_BITS'(r_y2);
            end
            default: begin
                w_mul_c = '0;
                w_mul_v = '0;
            end
        endcase
        if (i_cmd.mul_step[0]) begin
            w_mul_h = sbqhp_pkg::MOP_BITS'(
                signed'(w_mul_v[sbqhp_pkg::DIFF_BITS-1:sbqhp_pkg::LO_BITS]));
        end else begin
            w_mul_h = signed'({1'b0, w_mul_v[sbqhp_pkg::LO_BITS-1:0]});
        end
    end

    assign n_prod = w_mul_c * w_mul_h;

    // accumulate the registered partial product
    assign w_term = r_prod_hi ? (AB'(r_prod) <<< sbqhp_pkg::LO_BITS) : AB'(r_prod);
    assign n_acc  = r_prod_neg ? (r_acc - w_term) : (r_acc + w_term);

    // section result: round half up, drop fraction, saturate to data width
    assign w_rnd_sum   = r_acc + ACC_HALF;
    assign w_rnd_shift = w_rnd_sum >>> sbqhp_pkg::COEF_FRAC_BITS;
    always_comb begin
        if (w_rnd_shift > DATA_MAX) begin
            w_y = DATA_MAX[DB-1:0];
        end else if (w_rnd_shift < DATA_MIN) begin
            w_y = DATA_MIN[DB-1:0];
        end else begin
            w_y = w_rnd_shift[DB-1:0];
        end
    end

    // data registers of the section in progress
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_x    <= {i_in_data[SB-1:0], {sbqhp_pkg::DATA_FRAC{1'b0}}};
            r_in_r <= i_in_data[2*SB-1:SB];
        end
        if (i_cmd.cap_en) begin
            unique case (i_cmd.cap_sel)
                sbqhp_pkg::ENT_X1: r_x1 <= w_rd_val;
                sbqhp_pkg::ENT_X2: r_x2 <= w_rd_val;
                sbqhp_pkg::ENT_Y1: r_y1 <= w_rd_val;
                sbqhp_pkg::ENT_Y2: r_y2 <= w_rd_val;
                default:           r_x1 <= w_rd_val;
            endcase
        end
        if (i_cmd.diff_en) begin
            r_d <= sbqhp_pkg::DIFF_BITS'(r_x) - (sbqhp_pkg::DIFF_BITS'(r_x1) <<< 1)
                 + sbqhp_pkg::DIFF_BITS'(r_x2);
        end
        if (i_cmd.mul_en) begin
            r_prod     <= n_prod;
            r_prod_hi  <= i_cmd.mul_step[0];
            r_prod_neg <= (i_cmd.mul_step[2:1] != sbqhp_pkg::COEF_B0);
        end
        if (i_cmd.diff_en) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= n_acc;
        end
        // result feeds the next section, or the right channel starts
        if (i_cmd.rnd_en) begin
            if (i_cmd.last_sec && !i_cmd.ch) begin
                r_yl <= w_y;
                r_x  <= {r_in_r, {sbqhp_pkg::DATA_FRAC{1'b0}}};
            end else begin
                r_x <= w_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.mul_en;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_l <= f_to_sample(r_yl);
            r_out_r <= f_to_sample(r_x);
        end
    end

    assign o_sts.out_free = !r_out_vld || i_out_ready;
    assign o_out_valid    = r_out_vld;
    assign o_out_data     = sbqhp_pkg::TDATA_BITS'({r_out_r, r_out_l});

    // the store never sees a read and a write of one entry together
    a_rw_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd_en && i_cmd.wr_en) |-> (w_rd_addr != w_wr_addr))
        else $error("delay store read and write collide");

    // a finished word never overwrites one that has not been taken
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_vld || i_out_ready))
        else $error("output word overwritten");

    // the accumulator is never cleared while a product is still pending
    a_acc_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.diff_en |-> !r_prod_vld)
        else $error("accumulator cleared under a pending product");

endmodule

// ===== rtl/stereo_biquad_cascade_highpass.sv =====
// top level of the stereo tenth-order highpass biquad cascade
// depends on sbqhp_pkg, sbqhp_ctrl, sbqhp_dp (and sbqhp_ram below it)
//
//  channel   direction  handshake               payload
//  s_axis    in         tvalid / tready         tdata: left_in, right_in
//  m_axis    out        tvalid / tready         tdata: left_out, right_out
//  cfg       in         i_cfg_wr_en (no wait)   i_cfg_idx, i_cfg_wdata
//
// a new input word is accepted only once the previous word has left the cascade;
// each section needs 4 delay store reads, a difference step, 6 passes through
// the single 21x23 multiplier, an accumulate step and a rounding step.
// i_rst_n is synchronous; coefficients and the delay store read as zero after it.
// the next input word is taken while a result still waits on m_axis_tready;
// a stalled result holds the cascade only at its final step.
module stereo_biquad_cascade_highpass (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [23:0] left_in, [47:24] right_in
    input  logic [sbqhp_pkg::TDATA_BITS-1:0]     s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [23:0] left_out, [47:24] right_out
    output logic [sbqhp_pkg::TDATA_BITS-1:0]     m_axis_tdata,
    input  logic                                 i_cfg_wr_en,
    input  logic [sbqhp_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [sbqhp_pkg::REG_BITS-1:0]       i_cfg_wdata
);

    sbqhp_pkg::t_dp_cmd w_cmd;
    sbqhp_pkg::t_dp_sts w_sts;

    // sequencer
    sbqhp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // arithmetic and storage
    sbqhp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (s_axis_tdata),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule
